FILE: src/mads_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mads_pkg
// Shared types and constants for the minimum delete sum block.
// ----------------------------------------------------------------------------
package mads_pkg;

  localparam int CMD_W  = 2;
  localparam int CH_W   = 8;
  localparam int DSUM_W = 15;

  localparam logic [DSUM_W-1:0] SUM_LIMIT = 15'h7fff;

  typedef enum logic [CMD_W-1:0] {
    CMD_FIRST  = 2'd0,
    CMD_SECOND = 2'd1,
    CMD_FINISH = 2'd2
  } cmd_t;

  // Token moving down the cell chain, one per row of the first string.
  typedef struct packed {
    logic            valid;
    logic            last;
    logic [CH_W-1:0] ch;
  } tok_t;

  // Broadcast from the top level to every cell.
  typedef struct packed {
    logic            wr;
    logic            clear;
    logic [CH_W-1:0] ch;
  } ld_t;

endpackage

FILE: src/mads_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mads_in_if
// Input channel: one command with its character per transfer.
// ----------------------------------------------------------------------------
interface mads_in_if
  import mads_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [CH_W-1:0]  ch;

  modport source (output valid, output cmd, output ch, input ready);
  modport sink   (input valid, input cmd, input ch, output ready);
endinterface

FILE: src/mads_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mads_out_if
// Output channel: one delete sum and its overflow flag per transfer.
// ----------------------------------------------------------------------------
interface mads_out_if
  import mads_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [DSUM_W-1:0] delete_sum;
  logic              overflowed;

  modport source (output valid, output delete_sum, output overflowed, input ready);
  modport sink   (input valid, input delete_sum, input overflowed, output ready);
endinterface

FILE: src/mads_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mads_cell
// One column of the cost table: holds a character of the second string, its
// cost from the previous row and the diagonal cost, and passes each row on.
// ----------------------------------------------------------------------------
module mads_cell
  import mads_pkg::*;
#(
  parameter int INDEX = 0,
  parameter int IDX_W = 6,
  parameter int SUM_W = 15
) (
  input  logic             clk,
  input  logic             rst,
  input  ld_t              ld,
  input  logic [IDX_W-1:0] ld_idx,
  input  logic [SUM_W-1:0] ld_base,
  input  logic [SUM_W-1:0] ld_init,
  input  tok_t             i_tok,
  input  logic [SUM_W-1:0] i_left,
  output tok_t             o_tok,
  output logic [SUM_W-1:0] o_left
);

  logic [CH_W-1:0]  b;
  logic [SUM_W-1:0] up;
  logic [SUM_W-1:0] diag;
  logic             active;
  logic             hit;
  logic [SUM_W-1:0] drop_first;
  logic [SUM_W-1:0] drop_second;
  logic [SUM_W-1:0] val;

  assign hit = ld.wr && (ld_idx == IDX_W'(INDEX));

  always_comb begin
    drop_first  = up + SUM_W'(i_tok.ch);
    drop_second = i_left + SUM_W'(b);
    if (i_tok.ch == b) begin
      val = diag;
    end else if (drop_first < drop_second) begin
      val = drop_first;
    end else begin
      val = drop_second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      o_tok  <= '0;
    end else begin
      if (ld.clear) begin
        active <= 1'b0;
      end else if (hit) begin
        active <= 1'b1;
      end
      o_tok <= i_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      b    <= ld.ch;
      diag <= ld_base;
      up   <= ld_init;
    end else if (i_tok.valid && active) begin
      up   <= val;
      diag <= i_left;
    end
    // Empty columns pass the row cost straight through.
    o_left <= active ? val : i_left;
  end

endmodule

FILE: src/min_ascii_delete_sum_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_ascii_delete_sum_top
// Minimum total of character codes deleted from two strings to make them
// equal, computed by a systolic row of cells over the second string.
// ----------------------------------------------------------------------------
// Usage:
//   din carries cmd and ch. cmd CMD_FIRST or CMD_SECOND appends ch to that
//   string, one transfer per cycle while idle; characters past MAX_LEN are dropped
//   and flag overflow. cmd CMD_FINISH starts the sweep; unused codes are dropped.
//   dout carries delete_sum and overflowed, one transfer per finish.
// Sweep:
//   On a finish the first string streams through the chain one character
//   a cycle, and every row token crosses all MAX_LEN cells before the sum
//   leaves the end of the chain. With an empty first string the sum of the
//   second string is taken directly, without a sweep.
// Reset:
//   rst (synchronous) empties both strings and clears the overflow flag.
// Stalls:
//   The result sits in the output register until taken; new characters are
//   accepted meanwhile. A further finish waits for that register to drain.
// ----------------------------------------------------------------------------
module min_ascii_delete_sum_top
  import mads_pkg::*;
#(
  parameter int MAX_LEN = 64
) (
  input logic          clk,
  input logic          rst,
  mads_in_if.sink      din,
  mads_out_if.source   dout
);

  localparam int IDX_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LEN_W  = $clog2(MAX_LEN + 1);
  localparam int SUM_W  = $clog2(2 * MAX_LEN * 255 + 1);
  localparam int WIDE_W = (SUM_W > DSUM_W) ? SUM_W : DSUM_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FEED  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t            state;
  logic [LEN_W-1:0]  first_length;
  logic [LEN_W-1:0]  second_length;
  logic [SUM_W-1:0]  second_sum;
  logic              overflow_seen;
  logic [CH_W-1:0]   first_text [0:MAX_LEN-1];
  logic [IDX_W-1:0]  rd_addr;
  logic [CH_W-1:0]   rd_data;
  logic              rd_valid;
  logic              rd_last;
  logic [SUM_W-1:0]  asum;
  tok_t              inj;
  logic [SUM_W-1:0]  inj_left;
  logic [DSUM_W-1:0] res;

  tok_t              tok  [0:MAX_LEN];
  logic [SUM_W-1:0]  left [0:MAX_LEN];

  ld_t               ld;
  logic [SUM_W-1:0]  ld_init;
  logic              in_fire;
  logic              fire_first;
  logic              fire_second;
  logic              fire_finish;
  logic              first_room;
  logic              second_room;
  logic              done_fire;
  logic              end_hit;
  logic [SUM_W-1:0]  asum_next;
  logic [WIDE_W-1:0] wide_end;
  logic [WIDE_W-1:0] wide_second;
  logic [DSUM_W-1:0] sat_end;
  logic [DSUM_W-1:0] sat_second;

  assign din.ready   = (state == S_IDLE);
  assign in_fire     = din.valid && din.ready;
  assign fire_first  = in_fire && (din.cmd == CMD_FIRST);
  assign fire_second = in_fire && (din.cmd == CMD_SECOND);
  assign fire_finish = in_fire && (din.cmd == CMD_FINISH);
  assign first_room  = first_length < LEN_W'(MAX_LEN);
  assign second_room = second_length < LEN_W'(MAX_LEN);
  assign done_fire   = (state == S_DONE) && (!dout.valid || dout.ready);
  assign end_hit     = tok[MAX_LEN].valid && tok[MAX_LEN].last;
  assign asum_next   = asum + SUM_W'(rd_data);

  // Saturate to the reported width.
  assign wide_end    = WIDE_W'(left[MAX_LEN]);
  assign wide_second = WIDE_W'(second_sum);
  assign sat_end     = (wide_end > WIDE_W'(SUM_LIMIT)) ? SUM_LIMIT : wide_end[DSUM_W-1:0];
  assign sat_second  = (wide_second > WIDE_W'(SUM_LIMIT)) ? SUM_LIMIT
                                                           : wide_second[DSUM_W-1:0];

  // Cell loads and the clear after a finish.
  always_comb begin
    ld.wr    = fire_second && second_room;
    ld.clear = done_fire;
    ld.ch    = din.ch;
    ld_init  = second_sum + SUM_W'(din.ch);
  end

  // First string store.
  always_ff @(posedge clk) begin
    if (fire_first && first_room) begin
      first_text[IDX_W'(first_length)] <= din.ch;
    end
    rd_data <= first_text[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      first_length  <= '0;
      second_length <= '0;
      second_sum    <= '0;
      overflow_seen <= 1'b0;
      rd_addr       <= '0;
      rd_valid      <= 1'b0;
      rd_last       <= 1'b0;
      asum          <= '0;
      inj           <= '0;
      dout.valid    <= 1'b0;
    end else begin
      if (dout.ready && !done_fire) begin
        dout.valid <= 1'b0;
      end

      // Append.
      if (fire_first) begin
        if (first_room) begin
          first_length <= first_length + LEN_W'(1);
        end else begin
          overflow_seen <= 1'b1;
        end
      end
      if (fire_second) begin
        if (second_room) begin
          second_length <= second_length + LEN_W'(1);
          second_sum    <= ld_init;
        end else begin
          overflow_seen <= 1'b1;
        end
      end

      // Read stage, then injection into the head of the chain.
      rd_valid <= (state == S_FEED);
      rd_last  <= (state == S_FEED) && (rd_addr == IDX_W'(first_length - LEN_W'(1)));
      inj.valid <= rd_valid;
      inj.last  <= rd_last;
      inj.ch    <= rd_data;
      if (rd_valid) begin
        asum <= asum_next;
      end

      unique case (state)
        S_IDLE: begin
          if (fire_finish) begin
            rd_addr <= '0;
            asum    <= '0;
            if (first_length == '0) begin
              state <= S_DONE;
            end else begin
              state <= S_FEED;
            end
          end
        end
        S_FEED: begin
          rd_addr <= rd_addr + IDX_W'(1);
          if (rd_addr == IDX_W'(first_length - LEN_W'(1))) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (end_hit) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (done_fire) begin
            dout.valid    <= 1'b1;
            first_length  <= '0;
            second_length <= '0;
            second_sum    <= '0;
            overflow_seen <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result and output payload.
  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && fire_finish) begin
      res <= sat_second;
    end else if ((state == S_DRAIN) && end_hit) begin
      res <= sat_end;
    end
    if (rd_valid) begin
      inj_left <= asum_next;
    end
    if (done_fire) begin
      dout.delete_sum <= res;
      dout.overflowed <= overflow_seen;
    end
  end

  assign tok[0]  = inj;
  assign left[0] = inj_left;

  for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
    mads_cell #(
      .INDEX (k),
      .IDX_W (IDX_W),
      .SUM_W (SUM_W)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ld      (ld),
      .ld_idx  (IDX_W'(second_length)),
      .ld_base (second_sum),
      .ld_init (ld_init),
      .i_tok   (tok[k]),
      .i_left  (left[k]),
      .o_tok   (tok[k+1]),
      .o_left  (left[k+1])
    );
  end

endmodule
